/* rtl/tws_pkg.sv */
`default_nettype none

package tws_pkg;

  // Default table size: node count and letters per node
  localparam int NODES_DEF    = 1024;
  localparam int ALPHABET_DEF = 26;

  // Request opcodes; the fourth code carries no operation
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_PREFIX = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

/* rtl/tws_node_table.sv */
`default_nettype none

module tws_node_table
  import tws_pkg::*;
#(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF,
  localparam int AW      = $clog2(NODES),
  localparam int RW      = ALPHABET * AW + 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [RW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [RW-1:0] wr_data,
  output logic               clearing
);

  // One row per node: bit 0 is the word-end mark, then one child link per letter
  logic [RW-1:0] mem [NODES];
  logic [AW-1:0] clr_addr;

  // Sweep every row to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(NODES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port: the sweep takes it while clearing
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* rtl/trie_word_store.sv */
// Word store kept as a prefix trie in a node table.
// Input stream s_*: one request per letter of a word. tdata carries the letter,
// tuser the opcode (insert, exact search, prefix search) and the empty-word flag,
// tlast marks the final letter. A request with the unused opcode is dropped.
// Output stream m_*: one result per word, sent after the tlast request, with the
// found flag and the out-of-nodes flag of an insert.
// A letter that is not last is accepted and then its node row is read,
// modified and written; the row read is registered, and the next row address
// is the child found by the previous letter. A last letter then has the row of
// its final node read again to test or set its word-end mark, and the result
// is loaded into the output register in the finish state. A new letter is
// taken only in the idle state. Reset clears the walk and then sweeps the node
// table, one row per cycle; s_tready stays low during the sweep.
// When the receiver stalls, the result holds in the output register and a last
// letter waits in its final state until the register is free; earlier letters
// of the next word are still taken while a result waits.

`default_nettype none

module trie_word_store
  import tws_pkg::*;
#(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // letter[4:0], zero[7:5]
  input  wire logic       s_tlast,   // is_last
  input  wire logic [2:0] s_tuser,   // opcode[1:0], is_empty[2]
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata    // found[0], out_of_nodes[1], zero[7:2]
);

  localparam int AW = $clog2(NODES);
  localparam int UW = $clog2(NODES + 1);
  localparam int LW = $clog2(ALPHABET);
  localparam int RW = ALPHABET * AW + 1;

  state_t        state, state_next;

  // Latched request
  logic [1:0]    op_r;
  logic [4:0]    letter_r;
  logic          last_r;
  logic          empty_r;

  // Walk state
  logic [AW-1:0] current_node, current_node_next;
  logic [UW-1:0] nodes_used, nodes_used_next;
  logic          walk_missed, walk_missed_next;
  logic          pool_exhausted, pool_exhausted_next;

  // Result register
  logic          found, found_next;
  logic          out_of_nodes, out_of_nodes_next;
  logic          m_tvalid_next;

  // Table port
  logic [RW-1:0] rd_data;
  logic          wr_en;
  logic [RW-1:0] wr_data;
  logic          clearing;

  logic          s_accept;
  logic          out_free;
  logic          stopped;
  logic          in_range;
  logic [LW-1:0] lidx;
  logic [AW-1:0] child;

  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign stopped  = walk_missed || pool_exhausted;
  assign in_range = int'(letter_r) < ALPHABET;
  assign lidx     = LW'(letter_r);
  assign child    = rd_data[1 + int'(lidx) * AW +: AW];
  assign m_tdata  = {6'b0, out_of_nodes, found};

  tws_node_table #(
    .NODES    (NODES),
    .ALPHABET (ALPHABET)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (current_node),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (current_node),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (!clearing) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_accept && s_tuser[1:0] != OP_NONE) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = last_r ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs and walk update
  always_comb begin
    s_tready            = (state == ST_IDLE);
    current_node_next   = current_node;
    nodes_used_next     = nodes_used;
    walk_missed_next    = walk_missed;
    pool_exhausted_next = pool_exhausted;
    found_next          = found;
    out_of_nodes_next   = out_of_nodes;
    m_tvalid_next       = m_tvalid && !m_tready;
    wr_en               = 1'b0;
    wr_data             = rd_data;
    case (state)
      // Follow or allocate the child link of this letter
      ST_EXEC: begin
        if (!empty_r && !stopped) begin
          if (!in_range) begin
            walk_missed_next = 1'b1;
          end else if (child == '0) begin
            if (op_r != OP_INSERT) begin
              walk_missed_next = 1'b1;
            end else if (nodes_used >= UW'(NODES)) begin
              pool_exhausted_next = 1'b1;
            end else begin
              wr_en = 1'b1;
              wr_data[1 + int'(lidx) * AW +: AW] = nodes_used[AW-1:0];
              nodes_used_next   = nodes_used + 1'b1;
              current_node_next = nodes_used[AW-1:0];
            end
          end else begin
            current_node_next = child;
          end
        end
      end
      // Report the word, set the word-end mark of an insert, and return the walk to the root
      ST_FINISH: begin
        if (out_free) begin
          m_tvalid_next     = 1'b1;
          out_of_nodes_next = 1'b0;
          case (op_r)
            OP_INSERT: begin
              found_next        = !stopped;
              out_of_nodes_next = pool_exhausted;
              if (!stopped) begin
                wr_en      = 1'b1;
                wr_data[0] = 1'b1;
              end
            end
            OP_SEARCH: begin
              found_next = !stopped && rd_data[0];
            end
            default: begin
              found_next = !stopped;
            end
          endcase
          current_node_next   = '0;
          walk_missed_next    = 1'b0;
          pool_exhausted_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      current_node   <= '0;
      nodes_used     <= UW'(1);
      walk_missed    <= 1'b0;
      pool_exhausted <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state          <= state_next;
      current_node   <= current_node_next;
      nodes_used     <= nodes_used_next;
      walk_missed    <= walk_missed_next;
      pool_exhausted <= pool_exhausted_next;
      m_tvalid       <= m_tvalid_next;
    end
  end

  // Hold the request and result payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      op_r     <= s_tuser[1:0];
      letter_r <= s_tdata[4:0];
      last_r   <= s_tlast;
      empty_r  <= s_tuser[2];
    end
    found        <= found_next;
    out_of_nodes <= out_of_nodes_next;
  end

endmodule

`default_nettype wire
